### sv/assert_macros.svh
// Shared assertion macros for the RGB PWM fade block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset
`define ASSERT_ALWAYS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("rpwm: invariant violated");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rpwm: implication violated");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rpwm: next-cycle check violated");

`endif

### sv/rpwm_pkg.sv
package rpwm_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned PWM_PERIOD_DEF = 255;

  // Acceleration thresholds for the ramp step size
  localparam logic [DUTY_W-1:0] ACCEL_LOW  = 8'hA0;
  localparam logic [DUTY_W-1:0] ACCEL_HIGH = 8'hC7;
  localparam logic [DUTY_W-1:0] ADD3_LIMIT = 8'hFD;
  localparam logic [DUTY_W-1:0] ADD2_LIMIT = 8'hFE;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2
  } op_t;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [1:0]        channel;
    logic [DUTY_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic              blue_on;
    logic              green_on;
    logic              red_on;
    logic              ramp_done;
    logic [DUTY_W-1:0] duty_now;
  } result_t;

  // Request from the pipeline into the step engine
  typedef struct packed {
    logic  fire;
    item_t item;
  } step_req_t;

endpackage

### sv/rpwm_if.sv
interface rpwm_item_if;
  import rpwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [1:0]        channel;
  logic [DUTY_W-1:0] target;

  modport source (output valid, operation, channel, target, input ready);
  modport sink   (input valid, operation, channel, target, output ready);
endinterface

interface rpwm_result_if;
  import rpwm_pkg::*;

  logic              valid;
  logic              ready;
  logic              blue_on;
  logic              green_on;
  logic              red_on;
  logic              ramp_done;
  logic [DUTY_W-1:0] duty_now;

  modport source (output valid, blue_on, green_on, red_on, ramp_done, duty_now, input ready);
  modport sink   (input valid, blue_on, green_on, red_on, ramp_done, duty_now, output ready);
endinterface

### sv/rpwm_engine.sv
`include "assert_macros.svh"

module rpwm_engine #(
  parameter int unsigned PWM_PERIOD = rpwm_pkg::PWM_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rpwm_pkg::step_req_t req,
  output rpwm_pkg::result_t   res
);
  import rpwm_pkg::*;

  localparam logic [DUTY_W-1:0] PERIOD_VAL = DUTY_W'(PWM_PERIOD);

  // Channel state
  logic [NUM_CH-1:0][DUTY_W-1:0] duty, duty_next;
  logic [DUTY_W-1:0]             cnt, cnt_next;
  logic [NUM_CH-1:0]             lit, lit_next;

  logic              ch_ok;
  logic [1:0]        ch_idx;
  logic [DUTY_W-1:0] d_cur;
  logic [DUTY_W-1:0] step;
  logic [DUTY_W-1:0] cnt_inc;
  logic              done;
  logic [NUM_CH-1:0] lit_off;
  logic [NUM_CH-1:0] nonzero;

  assign ch_ok  = req.item.channel < 2'(NUM_CH);
  assign ch_idx = ch_ok ? req.item.channel : CH_BLUE;
  assign d_cur  = duty[ch_idx];

  // PWM tick terms
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      lit_off[i] = lit[i] & (duty[i] != cnt);
      nonzero[i] = duty[i] != '0;
    end
  end
  assign cnt_inc = cnt + 8'd1;

  // Next state and step result
  always_comb begin
    duty_next = duty;
    cnt_next  = cnt;
    lit_next  = lit;
    done      = 1'b0;
    step      = 8'd1;
    case (req.item.operation)
      OP_TICK: begin
        if (cnt_inc == PERIOD_VAL) begin
          cnt_next = '0;
          lit_next = lit_off | nonzero;
        end else begin
          cnt_next = cnt_inc;
          lit_next = lit_off;
        end
      end
      OP_UP: begin
        if (d_cur inside {[ACCEL_HIGH:ADD3_LIMIT - 8'd1]}) step = 8'd3;
        else if (d_cur inside {[ACCEL_LOW:ADD2_LIMIT - 8'd1]}) step = 8'd2;
        if (!ch_ok || req.item.target <= d_cur) done = 1'b1;
        else duty_next[ch_idx] = d_cur + step;
      end
      OP_DOWN: begin
        if (d_cur >= ACCEL_HIGH) step = 8'd3;
        else if (d_cur >= ACCEL_LOW) step = 8'd2;
        if (!ch_ok || req.item.target >= d_cur) done = 1'b1;
        else duty_next[ch_idx] = d_cur - step;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  assign res.blue_on   = lit_next[CH_BLUE];
  assign res.green_on  = lit_next[CH_GREEN];
  assign res.red_on    = lit_next[CH_RED];
  assign res.ramp_done = done;
  assign res.duty_now  = ch_ok ? duty_next[ch_idx] : '0;

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= '0;
      cnt  <= '0;
      lit  <= '0;
    end else if (req.fire) begin
      duty <= duty_next;
      cnt  <= cnt_next;
      lit  <= lit_next;
    end
  end

  `ASSERT_ALWAYS(a_cnt_below_period, clk, rst, cnt < PERIOD_VAL)
  `ASSERT_NEXT(a_ramp_keeps_cnt, clk, rst, req.fire && req.item.operation != OP_TICK, $stable(cnt))
  `ASSERT_NEXT(a_done_keeps_duty, clk, rst, req.fire && done, $stable(duty))

endmodule

### sv/rgb_pwm_with_accelerated_fade_unit.sv
// Channel     Dir  Handshake     Payload
// item_in     in   valid/ready   operation, channel, target
// result_out  out  valid/ready   blue_on, green_on, red_on, ramp_done, duty_now
//
// One item per cycle sustained while result_out is ready; the result is registered and
// valid once the item has passed the input register, the step engine and a result register.
// Channel state updates as the item moves from the input to the result register.
// rst is synchronous and clears both stage valids and the channel state.
// A stalled result_out holds the result; item_in still takes one more item if the input register is empty.
`include "assert_macros.svh"

module rgb_pwm_with_accelerated_fade_unit #(
  parameter int unsigned PWM_PERIOD = rpwm_pkg::PWM_PERIOD_DEF
) (
  input logic           clk,
  input logic           rst,
  rpwm_item_if.sink     item_in,
  rpwm_result_if.source result_out
);
  import rpwm_pkg::*;

  logic      in_valid;
  item_t     in_item;
  logic      out_valid;
  result_t   out_res;
  logic      advance;
  step_req_t req;
  result_t   res;

  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;

  assign req.fire = advance;
  assign req.item = in_item;

  rpwm_engine #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_item.operation <= item_in.operation;
      in_item.channel   <= item_in.channel;
      in_item.target    <= item_in.target;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !result_out.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.blue_on   = out_res.blue_on;
  assign result_out.green_on  = out_res.green_on;
  assign result_out.red_on    = out_res.red_on;
  assign result_out.ramp_done = out_res.ramp_done;
  assign result_out.duty_now  = out_res.duty_now;

  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !in_valid, item_in.ready)
  `ASSERT_NEXT(a_stalled_item_kept, clk, rst, in_valid && !advance, in_valid && $stable(in_item))
  `ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rpwm_pkg::*;

  localparam int unsigned PERIOD = PWM_PERIOD_DEF;
  // Codes outside the defined ranges
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CH_NONE   = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Driven copies of the item channel and the result ready
  logic       tx_valid = 1'b0;
  logic [1:0] tx_op    = OP_TICK;
  logic [1:0] tx_ch    = CH_BLUE;
  logic [7:0] tx_tgt   = 8'h00;
  logic       rx_ready = 1'b0;

  rpwm_item_if   item_ch ();
  rpwm_result_if res_ch ();

  assign item_ch.valid     = tx_valid;
  assign item_ch.operation = tx_op;
  assign item_ch.channel   = tx_ch;
  assign item_ch.target    = tx_tgt;
  assign res_ch.ready      = rx_ready;

  rgb_pwm_with_accelerated_fade_unit #(
    .PWM_PERIOD (PERIOD)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (res_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // LED state as the block should hold it
  logic [7:0] duty_lvl [NUM_CH];
  logic [7:0] pwm_count;
  logic [2:0] lit_mask;
  result_t    pending_leds [$];
  int         mismatches = 0;
  int         burst_left = 0;

  initial begin
    for (int i = 0; i < NUM_CH; i++) duty_lvl[i] = 8'h00;
    pwm_count = 8'h00;
    lit_mask  = 3'b000;
  end

  // Apply one item to the LED state and return the result it should produce
  function automatic result_t advance_leds(logic [1:0] op, logic [1:0] ch, logic [7:0] tgt);
    result_t    r;
    logic [7:0] d;
    logic       done;
    logic       ch_ok;
    done  = 1'b0;
    ch_ok = (ch < NUM_CH);
    d     = ch_ok ? duty_lvl[ch] : 8'h00;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_CH; i++)
          if (duty_lvl[i] == pwm_count) lit_mask[i] = 1'b0;
        pwm_count = pwm_count + 8'd1;
        if (32'(pwm_count) == PERIOD) begin
          pwm_count = 8'h00;
          for (int i = 0; i < NUM_CH; i++)
            if (duty_lvl[i] != 8'h00) lit_mask[i] = 1'b1;
        end
      end
      OP_UP: begin
        if (!ch_ok || tgt <= d) begin
          done = 1'b1;
        end else begin
          // step size grows with the duty; duty stays below 255 here
          if (d >= ACCEL_HIGH && d < ADD3_LIMIT) d = d + 8'd3;
          else if (d >= ACCEL_LOW && d < ADD2_LIMIT) d = d + 8'd2;
          else d = d + 8'd1;
          duty_lvl[ch] = d;
        end
      end
      OP_DOWN: begin
        if (!ch_ok || tgt >= d) begin
          done = 1'b1;
        end else begin
          if (d >= ACCEL_HIGH) d = d - 8'd3;
          else if (d >= ACCEL_LOW) d = d - 8'd2;
          else d = d - 8'd1;
          duty_lvl[ch] = d;
        end
      end
      default: ;
    endcase
    r.blue_on   = lit_mask[0];
    r.green_on  = lit_mask[1];
    r.red_on    = lit_mask[2];
    r.ramp_done = done;
    r.duty_now  = ch_ok ? duty_lvl[ch] : 8'h00;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check the result taken at this edge, then predict the item taken at this edge
  always @(posedge clk) begin : track_leds
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_leds.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = pending_leds.pop_front();
        check_field("blue_on", 8'(want.blue_on), 8'(res_ch.blue_on));
        check_field("green_on", 8'(want.green_on), 8'(res_ch.green_on));
        check_field("red_on", 8'(want.red_on), 8'(res_ch.red_on));
        check_field("ramp_done", 8'(want.ramp_done), 8'(res_ch.ramp_done));
        check_field("duty_now", want.duty_now, res_ch.duty_now);
      end
    end
    if (!rst && tx_valid && item_ch.ready)
      pending_leds.push_back(advance_leds(tx_op, tx_ch, tx_tgt));
  end

  // Result side: switches between no stalls, scattered stalls and long stalls
  always @(negedge clk) begin : stall_pattern
    static int mode = 0;
    static int mode_left = 0;
    static int stall_left = 0;
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 2);
      mode_left = $urandom_range(32, 200);
    end else begin
      mode_left--;
    end
    case (mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rx_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 12);
          rx_ready <= 1'b0;
        end else begin
          rx_ready <= 1'b1;
        end
      end
    endcase
  end

  // Send one item; bursts of back-to-back items separated by random gaps
  task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [7:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        tx_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    tx_valid <= 1'b1;
    tx_op    <= op;
    tx_ch    <= ch;
    tx_tgt   <= tgt;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    tx_valid <= 1'b0;
    burst_left = 0;
    while (pending_leds.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every operation, bad codes, met targets
  task automatic test_corner_cases();
    send_item(OP_TICK, CH_NONE, 8'hFF);
    send_item(OP_UNUSED, CH_BLUE, 8'h00);
    send_item(OP_UNUSED, CH_NONE, 8'hFF);
    send_item(OP_UP, CH_BLUE, 8'hFF);
    send_item(OP_UP, CH_BLUE, 8'h00);
    send_item(OP_UP, CH_BLUE, 8'h01);
    send_item(OP_DOWN, CH_BLUE, 8'hFF);
    send_item(OP_DOWN, CH_BLUE, 8'h00);
    send_item(OP_DOWN, CH_BLUE, 8'h00);
    send_item(OP_UP, CH_NONE, 8'hFF);
    send_item(OP_DOWN, CH_NONE, 8'h00);
    send_item(OP_UP, CH_GREEN, 8'h02);
    send_item(OP_UP, CH_GREEN, 8'h02);
    send_item(OP_UP, CH_GREEN, 8'h02);
    send_item(OP_UP, CH_RED, 8'h80);
    send_item(OP_UP, CH_RED, 8'h80);
    send_item(OP_TICK, CH_GREEN, 8'h00);
    send_item(OP_TICK, CH_RED, 8'h55);
    send_item(OP_TICK, CH_BLUE, 8'hAA);
  endtask

  // One channel fades all the way up, then down toward a low target,
  // mixed with ticks, ramps on the other channels and junk items
  task automatic test_fade_sweep();
    int         sweep_ch;
    int         steps;
    int         pick;
    logic [7:0] low_tgt;
    sweep_ch = $urandom_range(0, NUM_CH - 1);
    low_tgt  = 8'($urandom_range(0, 8'h40));
    steps    = 0;
    while (steps < 205 + 150) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_item(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
      end else if (pick < 30) begin
        send_item($urandom_range(0, 1) ? OP_UP : OP_DOWN,
                  2'((sweep_ch + $urandom_range(1, 2)) % NUM_CH), 8'($urandom));
      end else if (pick < 35) begin
        if ($urandom_range(0, 1))
          send_item(OP_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom));
        else
          send_item(2'($urandom_range(0, 2)), CH_NONE, 8'($urandom));
      end else begin
        if (steps < 205) send_item(OP_UP, 2'(sweep_ch), 8'hFF);
        else send_item(OP_DOWN, 2'(sweep_ch), low_tgt);
        steps++;
      end
    end
  endtask

  // Mostly ticks, enough for a full PWM period with mixed duties
  task automatic test_pwm_periods();
    repeat (330) begin
      if ($urandom_range(0, 99) < 85)
        send_item(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
      else
        send_item($urandom_range(0, 1) ? OP_UP : OP_DOWN,
                  2'($urandom_range(0, NUM_CH - 1)), 8'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_cases();
    hold_until_drained();
    test_fade_sweep();
    hold_until_drained();
    test_pwm_periods();
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rpwm_pkg.sv
sv/rpwm_if.sv
sv/rpwm_engine.sv
sv/rgb_pwm_with_accelerated_fade_unit.sv
sim/testbench.sv
